// ===== sv/monotonic_stack_engine_defines.svh =====
// Assertion macros used by the RTL of the monotonic stack engine.
`ifndef MONOTONIC_STACK_ENGINE_DEFINES_SVH
`define MONOTONIC_STACK_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mse_pkg.sv =====
package mse_pkg;

  localparam int DATA_W = 32;
  localparam int DEPTH  = 128;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_NGE  = 2'd0;
  localparam logic [1:0] MODE_NSE  = 2'd1;
  localparam logic [1:0] MODE_SPAN = 2'd2;

  typedef enum logic [1:0] {
    OP_NGE  = 2'd0,
    OP_NSE  = 2'd1,
    OP_SPAN = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
    op_t                      op;
    logic [PTR_W-1:0]         pos;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [PTR_W-1:0]         idx;
  } ent_t;

endpackage

// ===== sv/mse_front.sv =====
module mse_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_data,
  input  logic                              in_valid,
  input  logic signed [mse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  input  mse_pkg::q_stat_t                  q_stat,
  output logic                              in_stall,
  output logic                              q_push,
  output mse_pkg::item_t                    q_item
);

  logic [1:0]               mode_r, mode_nxt;
  logic [mse_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic                     ovf;
  mse_pkg::op_t             op;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;
  assign ovf      = pos_r >= mse_pkg::CNT_W'(mse_pkg::DEPTH);

  always_comb begin
    case (mode_r)
      mse_pkg::MODE_NGE: op = mse_pkg::OP_NGE;
      mse_pkg::MODE_NSE: op = mse_pkg::OP_NSE;
      default:           op = mse_pkg::OP_SPAN;
    endcase
  end

  always_comb begin
    q_item.value = in_value;
    q_item.last  = in_last;
    q_item.ovf   = ovf;
    q_item.op    = op;
    q_item.pos   = pos_r[mse_pkg::PTR_W-1:0];
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    if (cfg_valid) begin
      mode_nxt = cfg_data;
    end
    if (q_push) begin
      if (in_last) begin
        pos_nxt = '0;
      end else if (!ovf) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mse_pkg::MODE_NGE;
      pos_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ===== sv/mse_queue.sv =====
module mse_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mse_pkg::item_t   push_item,
  input  logic             pop,
  output mse_pkg::q_stat_t stat,
  output mse_pkg::item_t   head
);

  mse_pkg::item_t slot_r [2];
  mse_pkg::item_t slot0_nxt, slot1_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;

  assign stat.valid = cnt_r != 2'd0;
  assign stat.full  = cnt_r == 2'd2;
  assign head       = slot_r[rd_r];

  always_comb begin
    slot0_nxt = slot_r[0];
    slot1_nxt = slot_r[1];
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    if (push) begin
      if (wr_r) begin
        slot1_nxt = push_item;
      end else begin
        slot0_nxt = push_item;
      end
      wr_nxt = !wr_r;
    end
    if (pop) begin
      rd_nxt = !rd_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot0_nxt;
    slot_r[1] <= slot1_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
    end
  end

endmodule

// ===== sv/mse_back.sv =====
`include "monotonic_stack_engine_defines.svh"

module mse_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mse_pkg::q_stat_t                   q_stat,
  input  mse_pkg::item_t                     q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mse_pkg::DATA_W-1:0]  out_answer,
  output logic                               out_found,
  output logic                               out_overflow,
  output logic                               out_end_of_sequence
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_LOAD = 3'b100
  } st_t;

  st_t                              st_r, st_nxt;
  mse_pkg::item_t                   cur_r, cur_nxt;
  logic [mse_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic signed [mse_pkg::DATA_W-1:0] top_val_r, top_val_nxt;
  logic [mse_pkg::PTR_W-1:0]        top_idx_r, top_idx_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [mse_pkg::DATA_W-1:0] answer_r, answer_nxt;
  logic                              found_r, found_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              eos_r, eos_nxt;

  mse_pkg::ent_t             mem [mse_pkg::DEPTH];
  mse_pkg::ent_t             rdata_r;
  logic                      mem_we, mem_re;
  logic [mse_pkg::PTR_W-1:0] waddr, raddr;

  logic                      out_free, nonempty, drop, pop_go, finish;
  logic [mse_pkg::CNT_W-1:0] span;

  assign out_free  = !out_valid_r || !out_stall;
  assign nonempty  = count_r != '0;
  assign waddr     = count_r[mse_pkg::PTR_W-1:0];
  assign raddr     = count_r[mse_pkg::PTR_W-1:0] - mse_pkg::PTR_W'(2);

  always_comb begin
    if (cur_r.op == mse_pkg::OP_NSE) begin
      drop = nonempty && (top_val_r >= cur_r.value);
    end else begin
      drop = nonempty && (top_val_r <= cur_r.value);
    end
  end

  assign pop_go = (st_r == ST_CMP) && !cur_r.ovf && drop;
  assign finish = (st_r == ST_CMP) && !pop_go && out_free;
  assign mem_we = finish && !cur_r.ovf;
  assign mem_re = pop_go;
  assign q_pop  = (st_r == ST_IDLE) && q_stat.valid;

  always_comb begin
    if (nonempty) begin
      span = {1'b0, cur_r.pos} - {1'b0, top_idx_r};
    end else begin
      span = {1'b0, cur_r.pos} + 1'b1;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    top_val_nxt   = top_val_r;
    top_idx_nxt   = top_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    answer_nxt    = answer_r;
    found_nxt     = found_r;
    ovf_nxt       = ovf_r;
    eos_nxt       = eos_r;
    case (st_r)
      ST_IDLE: begin
        if (q_stat.valid) begin
          cur_nxt = q_head;
          st_nxt  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (pop_go) begin
          count_nxt = count_r - 1'b1;
          st_nxt    = ST_LOAD;
        end else if (finish) begin
          out_valid_nxt = 1'b1;
          eos_nxt       = cur_r.last;
          ovf_nxt       = cur_r.ovf;
          if (cur_r.ovf) begin
            answer_nxt = '0;
            found_nxt  = 1'b0;
          end else begin
            if (cur_r.op == mse_pkg::OP_SPAN) begin
              answer_nxt = mse_pkg::DATA_W'(span);
              found_nxt  = 1'b1;
            end else begin
              answer_nxt = nonempty ? top_val_r : '1;
              found_nxt  = nonempty;
            end
            top_val_nxt = cur_r.value;
            top_idx_nxt = cur_r.pos;
            count_nxt   = count_r + 1'b1;
          end
          if (cur_r.last) begin
            count_nxt = '0;
          end
          st_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        top_val_nxt = rdata_r.value;
        top_idx_nxt = rdata_r.idx;
        st_nxt      = ST_CMP;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= '{value: cur_r.value, idx: cur_r.pos};
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    top_val_r <= top_val_nxt;
    top_idx_r <= top_idx_nxt;
    answer_r  <= answer_nxt;
    found_r   <= found_nxt;
    ovf_r     <= ovf_nxt;
    eos_r     <= eos_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_answer          = answer_r;
  assign out_found           = found_r;
  assign out_overflow        = ovf_r;
  assign out_end_of_sequence = eos_r;

  `MSE_ASSERT_IMP(a_push_room, mem_we, count_r < mse_pkg::CNT_W'(mse_pkg::DEPTH), "push into full stack")
  `MSE_ASSERT_NXT(a_pop_dec, pop_go, count_r == $past(count_r) - 1'b1, "pop did not shrink stack")
  `MSE_ASSERT_NXT(a_last_clear, finish && cur_r.last, count_r == '0, "stack not empty after last beat")
  `MSE_ASSERT_IMP(a_idx_order, mem_we && nonempty, top_idx_r < cur_r.pos, "stack index out of order")

endmodule

// ===== sv/monotonic_stack_engine.sv =====
// Monotonic stack engine: next greater element, next smaller element or stock span.
// Input channel in_valid/in_stall carries one beat per item: in_value (signed) and
// in_last, which marks the final item of a sequence and empties the stack after it.
// Output channel out_valid/out_stall carries one beat per item: out_answer, out_found,
// out_overflow and out_end_of_sequence, in item order.
// Configuration channel cfg_valid/cfg_ready writes the 2-bit mode register
// (0 next greater, 1 next smaller, 2 or 3 stock span); write it only while idle.
// An accepted beat waits in a two-entry queue until the stack unit is idle and takes it.
// The stack unit handles each item in its compare state and visits its load state
// for each entry it pops, since every pop reads the new top from the stack memory
// through its registered read port. Each entry is popped at most once, and the unit
// takes a new item only after it has registered the result of the last one.
// Items past the 128th of a sequence are flagged with out_overflow and not pushed.
// While out_stall holds a pending result, the result register holds and the stack
// unit cannot finish its item; the queue takes beats until full, then in_stall rises.
// Synchronous reset empties the stack, the queue and the result register, clears the
// item position and sets the mode to next greater element.
module monotonic_stack_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mse_pkg::DATA_W-1:0] out_answer,
  output logic                              out_found,
  output logic                              out_overflow,
  output logic                              out_end_of_sequence
);

  mse_pkg::q_stat_t q_stat;
  mse_pkg::item_t   q_item;
  mse_pkg::item_t   q_head;
  logic             q_push;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  mse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_value  (in_value),
    .in_last   (in_last),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  mse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .stat      (q_stat),
    .head      (q_head)
  );

  mse_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_answer          (out_answer),
    .out_found           (out_found),
    .out_overflow        (out_overflow),
    .out_end_of_sequence (out_end_of_sequence)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPAN_ALT = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 130;

  localparam int STYLE_WIDE   = 0;
  localparam int STYLE_NARROW = 1;
  localparam int STYLE_RISE   = 2;
  localparam int STYLE_FALL   = 3;
  localparam int STYLE_CORNER = 4;

  localparam logic signed [mse_pkg::DATA_W-1:0] VAL_MAX =
    {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [mse_pkg::DATA_W-1:0] VAL_MIN =
    {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [mse_pkg::DATA_W-1:0] value;
    logic                              last;
  } stack_item_t;

  typedef struct packed {
    logic signed [mse_pkg::DATA_W-1:0] answer;
    logic                              found;
    logic                              overflow;
    logic                              eos;
  } stack_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [mse_pkg::DATA_W-1:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [mse_pkg::DATA_W-1:0] out_answer;
  logic out_found;
  logic out_overflow;
  logic out_end_of_sequence;

  stack_item_t items_to_send[$];
  stack_answer_t answers_due[$];

  logic [1:0] shadow_mode = mse_pkg::MODE_NGE;
  logic signed [mse_pkg::DATA_W-1:0] shadow_values[mse_pkg::DEPTH];
  int shadow_index[mse_pkg::DEPTH];
  int shadow_count = 0;
  int shadow_position = 0;

  int error_count = 0;
  int cycle_count = 0;
  int items_accepted = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_kind = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic [1:0] hold_fired = 2'b00;
  stack_item_t next_item;

  monotonic_stack_engine uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_value            (in_value),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_answer          (out_answer),
    .out_found           (out_found),
    .out_overflow        (out_overflow),
    .out_end_of_sequence (out_end_of_sequence)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("mismatch in %s at cycle %0d: expected %0d, got %0d", field, cycle_count, want,
             got);
    error_count++;
  endtask

  task automatic advance_stack(input logic signed [mse_pkg::DATA_W-1:0] v, input logic lst);
    stack_answer_t res;
    logic drop;
    res = '0;
    res.eos = lst;
    if (shadow_position >= mse_pkg::DEPTH || shadow_count >= mse_pkg::DEPTH) begin
      res.overflow = 1'b1;
    end else begin
      if (shadow_mode == mse_pkg::MODE_NGE || shadow_mode == mse_pkg::MODE_NSE) begin
        drop = 1'b1;
        while (shadow_count > 0 && drop) begin
          if (shadow_mode == mse_pkg::MODE_NGE) begin
            drop = shadow_values[shadow_count-1] <= v;
          end else begin
            drop = shadow_values[shadow_count-1] >= v;
          end
          if (drop) shadow_count--;
        end
        if (shadow_count > 0) begin
          res.answer = shadow_values[shadow_count-1];
          res.found = 1'b1;
        end else begin
          res.answer = -1;
        end
      end else begin
        while (shadow_count > 0 && shadow_values[shadow_count-1] <= v) shadow_count--;
        if (shadow_count > 0) begin
          res.answer = shadow_position - shadow_index[shadow_count-1];
        end else begin
          res.answer = shadow_position + 1;
        end
        res.found = 1'b1;
      end
      shadow_values[shadow_count] = v;
      shadow_index[shadow_count] = shadow_position;
      shadow_count++;
      shadow_position++;
    end
    if (lst) begin
      shadow_count = 0;
      shadow_position = 0;
    end
    answers_due.push_back(res);
  endtask

  // The sender offers items in bursts, mostly separated by idle gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      in_last <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_stack(in_value, in_last);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          next_item = items_to_send.pop_front();
          in_value <= next_item.value;
          in_last <= next_item.last;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(9) == 0) ? 200 : $urandom_range(1, 30);
            gap_left <= ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs so that the engine fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (items_accepted >= 600 && !hold_fired[0]) begin
      hold_fired[0] <= 1'b1;
      hold_left <= 300;
    end else if (items_accepted >= 1400 && !hold_fired[1]) begin
      hold_fired[1] <= 1'b1;
      hold_left <= 300;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_kind <= $urandom_range(3);
        stall_left <= $urandom_range(20, 120);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_kind)
        0: out_stall <= (hold_left != 0);
        1: out_stall <= (hold_left != 0) || ($urandom_range(3) == 0);
        2: out_stall <= (hold_left != 0) || ($urandom_range(3) != 0);
        default: out_stall <= (hold_left != 0) || stall_left[0];
      endcase
    end
  end

  always @(posedge clk) begin
    stack_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = answers_due.pop_front();
        if (out_answer !== want.answer) report_mismatch("answer", want.answer, out_answer);
        if (out_found !== want.found) report_mismatch("found", want.found, out_found);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", want.overflow, out_overflow);
        if (out_end_of_sequence !== want.eos)
          report_mismatch("end_of_sequence", want.eos, out_end_of_sequence);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[monotonic_stack_engine] ERROR");
      $finish;
    end
  end

  task automatic add_item(input logic signed [mse_pkg::DATA_W-1:0] v, input logic lst);
    stack_item_t it;
    it.value = v;
    it.last = lst;
    items_to_send.push_back(it);
  endtask

  function automatic logic signed [mse_pkg::DATA_W-1:0] pick_value(input int style,
                                                                   input int k,
                                                                   input int base,
                                                                   input int step);
    case (style)
      STYLE_WIDE: return $urandom();
      STYLE_NARROW: return $signed($urandom_range(8)) - 4;
      STYLE_RISE: return base + k * step;
      STYLE_FALL: return base - k * step;
      default: begin
        case ($urandom_range(5))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return 0;
          3: return -1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  task automatic add_sequence(input int len, input int style, input logic close);
    int base;
    int step;
    base = $signed($urandom_range(2000000)) - 1000000;
    step = $urandom_range(1, 1000);
    for (int k = 0; k < len; k++) begin
      add_item(pick_value(style, k, base, step), close && (k == len - 1));
    end
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_mode = m;
    cfg_valid <= 1'b0;
  endtask

  // Sampled away from the rising edge so that every update of the edge has settled.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid || answers_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int fill;
    int len;
    int pick;
    logic [1:0] m;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_item(VAL_MAX, 1'b0);
    add_item(VAL_MIN, 1'b0);
    add_item(0, 1'b0);
    add_item(-1, 1'b0);
    add_item(5, 1'b0);
    add_item(5, 1'b0);
    add_item(VAL_MIN, 1'b1);
    wait_idle();
    write_mode(mse_pkg::MODE_NSE);
    add_item(VAL_MIN, 1'b0);
    add_item(VAL_MAX, 1'b0);
    add_item(3, 1'b0);
    add_item(3, 1'b0);
    add_item(-1, 1'b0);
    add_item(VAL_MAX, 1'b1);
    wait_idle();
    write_mode(mse_pkg::MODE_SPAN);
    add_item(100, 1'b0);
    add_item(80, 1'b0);
    add_item(60, 1'b0);
    add_item(70, 1'b0);
    add_item(60, 1'b0);
    add_item(75, 1'b0);
    add_item(85, 1'b1);
    wait_idle();
    write_mode(MODE_SPAN_ALT);
    add_item(VAL_MAX, 1'b0);
    add_item(VAL_MAX, 1'b0);
    add_item(VAL_MIN, 1'b0);
    wait_idle();
    write_mode(mse_pkg::MODE_NGE);
    add_item(0, 1'b0);
    add_item(7, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      m = (phase < 4) ? phase[1:0] : 2'($urandom_range(3));
      write_mode(m);
      if (phase == 0) add_sequence(131, STYLE_FALL, 1'b1);
      if (phase == 2) add_sequence(130, STYLE_FALL, 1'b1);
      fill = 0;
      while (fill < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          len = $urandom_range(1, 24);
        end else if (pick < 96) begin
          len = $urandom_range(25, 100);
        end else begin
          len = $urandom_range(129, 140);
        end
        fill += len;
        add_sequence(len, $urandom_range(4), (fill < PHASE_ITEMS) || ($urandom_range(1) == 1));
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("[monotonic_stack_engine] OK");
    end else begin
      $display("[monotonic_stack_engine] ERROR");
    end
    $finish;
  end

endmodule
